// ===== src/lf2d_pkg.sv =====
`timescale 1ns / 1ps
// lf2d_pkg: shared widths, source format codes, status codes and constants
// for the foreign-float to ieee double converter; no dependencies
package lf2d_pkg;

    localparam int WORD_W   = 64;
    localparam int MANT16_W = 56;
    localparam int LZ_W     = 6;
    localparam int FMT_W    = 3;
    localparam int ST_W     = 2;

    // source format codes
    localparam logic [FMT_W-1:0] FMT_IEEE_BIG    = 3'd0;
    localparam logic [FMT_W-1:0] FMT_IEEE_LITTLE = 3'd1;
    localparam logic [FMT_W-1:0] FMT_BASE2_SWAP  = 3'd2;
    localparam logic [FMT_W-1:0] FMT_BASE16      = 3'd3;
    localparam logic [FMT_W-1:0] FMT_EXP15       = 3'd4;
    localparam logic [FMT_W-1:0] FMT_EXCESS1024  = 3'd5;

    // conversion status codes
    localparam logic [ST_W-1:0] ST_NORMAL  = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO    = 2'd1;
    localparam logic [ST_W-1:0] ST_NAN     = 2'd2;
    localparam logic [ST_W-1:0] ST_EXP_OOR = 2'd3;

    localparam logic [WORD_W-1:0] NAN_WORD = 64'hFFF0_0BAD_0BAD_0BAD;

    // exponent rebias amounts
    localparam logic [10:0] BASE2_REBIAS  = 11'd894;    // 1023 - 129
    localparam logic [15:0] EXP15_UNBIAS  = 16'd15362;  // 16384 + 1 - 1023
    localparam logic [15:0] EXP15_TOP     = 16'd17409;  // unbias + 2047
    localparam logic [10:0] EX1024_UNBIAS = 11'd2;      // 1024 + 1 - 1023
    localparam logic [11:0] BASE16_REBIAS = 12'd766;    // 898 - 33 * 4

endpackage

// ===== src/lf2d_norm.sv =====
`timescale 1ns / 1ps
// lf2d_norm: base-16 mantissa normaliser, registered leading-zero count
// followed by the shift and exponent rebias; depends on lf2d_pkg
module lf2d_norm (
    input  logic                           i_clk,
    input  logic [lf2d_pkg::MANT16_W-1:0]  i_mant,
    input  logic [6:0]                     i_exp,
    output logic [51:0]                    o_frac,
    output logic [11:0]                    o_exp
);
    import lf2d_pkg::*;

    logic [LZ_W-1:0]     n_lz;
    logic [LZ_W-1:0]     r_lz;
    logic [MANT16_W-1:0] r_mant;
    logic [6:0]          r_exp;
    logic [MANT16_W-1:0] w_shifted;

    // priority search, highest set bit wins
    always_comb begin
        n_lz = '0;
        for (int i = 0; i < MANT16_W; i++) begin
            if (i_mant[i]) begin
                n_lz = LZ_W'(MANT16_W - 1 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lz   <= n_lz;
        r_mant <= i_mant;
        r_exp  <= i_exp;
    end

    assign w_shifted = r_mant << r_lz;
    assign o_frac    = w_shifted[54:3];
    assign o_exp     = {3'b000, r_exp, 2'b00} + BASE16_REBIAS - {6'b000000, r_lz};

endmodule

// ===== src/legacy_float_to_ieee_double.sv =====
`timescale 1ns / 1ps
// legacy_float_to_ieee_double: top level, four-stage converter from foreign
// float formats to big-endian ieee double; depends on lf2d_pkg, lf2d_norm
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  --------------------------------
// input     in         start & !busy             i_foreign_word, i_last_in
// result    out        o_strobe (one cycle)      o_ieee_word, o_conv_status,
//                                                o_last_out
// config    in         i_cfg_valid & o_cfg_ready i_cfg_data (source format)
//
// one request per cycle is taken while busy is low; each result passes through
// four registered stages (input capture, decode and negate, leading-zero count,
// shift and final select), simple formats moving in step with the base-16 path
// busy is high only while reset is held and for the cycle after it
// the receiver cannot stall, so the pipeline never holds; valid bits travel
// with the data and nothing is lost or repeated
// the source format is sampled with each request on capture
module legacy_float_to_ieee_double (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lf2d_pkg::WORD_W-1:0]   i_foreign_word,
    input  logic                          i_last_in,
    output logic                          o_strobe,
    output logic [lf2d_pkg::WORD_W-1:0]   o_ieee_word,
    output logic [lf2d_pkg::ST_W-1:0]     o_conv_status,
    output logic                          o_last_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lf2d_pkg::FMT_W-1:0]    i_cfg_data
);
    import lf2d_pkg::*;

    // control and configuration
    logic             r_live;
    logic [FMT_W-1:0] r_source_format;
    logic             w_accept;

    // stage 1: captured request
    logic              r_s1_valid;
    logic [WORD_W-1:0] r_s1_word;
    logic              r_s1_last;
    logic [FMT_W-1:0]  r_s1_fmt;

    // stage 2: decoded; simple formats finished here
    logic                n_s2_word;
    logic [WORD_W-1:0]   n_word;
    logic [ST_W-1:0]     n_st;
    logic [MANT16_W-1:0] n_mant;
    logic [6:0]          n_exp7;
    logic                r_s2_valid;
    logic                r_s2_last;
    logic                r_s2_is16;
    logic [WORD_W-1:0]   r_s2_word;
    logic [ST_W-1:0]     r_s2_st;
    logic                r_s2_sign;
    logic                r_s2_zero16;
    logic [MANT16_W-1:0] r_s2_mant;
    logic [6:0]          r_s2_exp7;

    // stage 3: leading-zero count held inside the normaliser
    logic              r_s3_valid;
    logic              r_s3_last;
    logic              r_s3_is16;
    logic [WORD_W-1:0] r_s3_word;
    logic [ST_W-1:0]   r_s3_st;
    logic              r_s3_sign;
    logic              r_s3_zero16;
    logic [51:0]       w_frac16;
    logic [11:0]       w_exp16;

    // stage 4: result registers
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic [ST_W-1:0]   r_out_st;
    logic              r_out_last;
    logic [WORD_W-1:0] n_out_word;
    logic [ST_W-1:0]   n_out_st;

    // decode scratch
    logic [WORD_W-1:0] w_in;
    logic [WORD_W-1:0] w_swapped;
    logic [31:0]       w_hi;
    logic [31:0]       w_lo;
    logic [10:0]       w_exp_b2;
    logic [15:0]       w_exp15_raw;
    logic [15:0]       w_exp15;
    logic [10:0]       w_exp_ex;

    assign busy        = ~r_live;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live          <= 1'b0;
            r_source_format <= FMT_IEEE_BIG;
        end else begin
            r_live <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                r_source_format <= i_cfg_data;
            end
        end
    end

    // ---- stage 1: capture ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_word <= i_foreign_word;
            r_s1_last <= i_last_in;
            r_s1_fmt  <= r_source_format;
        end
    end

    // ---- stage 2: decode ----
    assign w_in = r_s1_word;

    // little-endian ieee: full byte reverse
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_swapped[8*k +: 8] = w_in[WORD_W-8-8*k +: 8];
        end
    end

    // base-2 word-swapped: bytes 1,0,3,2 and 5,4,7,6 (byte 0 in the top bits)
    assign w_hi     = {w_in[55:48], w_in[63:56], w_in[39:32], w_in[47:40]};
    assign w_lo     = {w_in[23:16], w_in[31:24], w_in[7:0], w_in[15:8]};
    assign w_exp_b2 = {3'b000, w_hi[30:23]} + BASE2_REBIAS;

    // 15-bit exponent and excess-1024 rebias
    assign w_exp15_raw = {1'b0, w_in[62:48]};
    assign w_exp15     = w_exp15_raw - EXP15_UNBIAS;
    assign w_exp_ex    = w_in[62:52] - EX1024_UNBIAS;

    always_comb begin
        n_word    = NAN_WORD;
        n_st      = ST_NAN;
        n_s2_word = 1'b0;
        // base-16 operand: two's-complement mantissa, exponent complemented
        n_mant = w_in[63] ? (~w_in[MANT16_W-1:0] + 56'd1) : w_in[MANT16_W-1:0];
        n_exp7 = w_in[63] ? ~w_in[62:56] : w_in[62:56];
        case (r_s1_fmt)
            FMT_IEEE_BIG: begin
                n_word = w_in;
                n_st   = (w_in == '0) ? ST_ZERO : ST_NORMAL;
            end
            FMT_IEEE_LITTLE: begin
                n_word = w_swapped;
                n_st   = (w_in == '0) ? ST_ZERO : ST_NORMAL;
            end
            FMT_BASE2_SWAP: begin
                if (w_hi[30:23] == 8'd0) begin
                    // clear sign is zero, set sign is the reserved operand
                    if (w_hi[31]) begin
                        n_word = NAN_WORD;
                        n_st   = ST_NAN;
                    end else begin
                        n_word = '0;
                        n_st   = ST_ZERO;
                    end
                end else begin
                    n_word = {w_hi[31], w_exp_b2, w_hi[22:0], w_lo[31:3]};
                    n_st   = ST_NORMAL;
                end
            end
            FMT_BASE16: begin
                n_s2_word = 1'b1;
            end
            FMT_EXP15: begin
                if (w_in == '0) begin
                    n_word = '0;
                    n_st   = ST_ZERO;
                end else if (w_exp15_raw < EXP15_UNBIAS || w_exp15_raw > EXP15_TOP) begin
                    n_word = NAN_WORD;
                    n_st   = ST_NAN;
                end else begin
                    n_word = {w_in[63], w_exp15[10:0], w_in[46:0], 5'b00000};
                    n_st   = ST_NORMAL;
                end
            end
            FMT_EXCESS1024: begin
                if (w_in == '0) begin
                    n_word = '0;
                    n_st   = ST_ZERO;
                end else if (w_in[62:52] < EX1024_UNBIAS) begin
                    n_word = NAN_WORD;
                    n_st   = ST_NAN;
                end else begin
                    n_word = {w_in[63], w_exp_ex, w_in[51:0]};
                    n_st   = ST_NORMAL;
                end
            end
            default: begin
                // reserved format codes
                n_word = NAN_WORD;
                n_st   = ST_NAN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_last   <= r_s1_last;
        r_s2_is16   <= n_s2_word;
        r_s2_word   <= n_word;
        r_s2_st     <= n_st;
        r_s2_sign   <= w_in[63];
        r_s2_zero16 <= (n_mant == '0);
        r_s2_mant   <= n_mant;
        r_s2_exp7   <= n_exp7;
    end

    // ---- stage 3: base-16 leading-zero count ----
    lf2d_norm u_norm (
        .i_clk  (i_clk),
        .i_mant (r_s2_mant),
        .i_exp  (r_s2_exp7),
        .o_frac (w_frac16),
        .o_exp  (w_exp16)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_last   <= r_s2_last;
        r_s3_is16   <= r_s2_is16;
        r_s3_word   <= r_s2_word;
        r_s3_st     <= r_s2_st;
        r_s3_sign   <= r_s2_sign;
        r_s3_zero16 <= r_s2_zero16;
    end

    // ---- stage 4: shift, rebias and final select ----
    always_comb begin
        n_out_word = r_s3_word;
        n_out_st   = r_s3_st;
        if (r_s3_is16) begin
            if (r_s3_zero16) begin
                n_out_word = '0;
                n_out_st   = ST_ZERO;
            end else begin
                // out-of-range exponent keeps its low 11 bits, flagged
                n_out_word = {r_s3_sign, w_exp16[10:0], w_frac16};
                n_out_st   = w_exp16[11] ? ST_EXP_OOR : ST_NORMAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_out_st   <= n_out_st;
        r_out_last <= r_s3_last;
    end

    assign o_strobe      = r_out_valid;
    assign o_ieee_word   = r_out_word;
    assign o_conv_status = r_out_st;
    assign o_last_out    = r_out_last;

endmodule
